// ----- rtl/core/lru_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the LRU page replacement unit.
// No dependencies; used by lru_cell and lru_page_replacement.
package lru_pkg;

  localparam int FRAME_COUNT_DEF = 8;
  localparam int PAGE_BITS_DEF   = 16;

  localparam int PAGE_NUM_W = 16;
  localparam int CFG_W      = 4;
  localparam int FAULT_W    = 32;

  localparam logic [CFG_W-1:0]   FRAMES_RESET = 4'd8;
  localparam logic [FAULT_W-1:0] FAULT_MAX    = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } lru_state_t;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic cmp_en;
    logic upd_en;
  } lru_ctl_t;

endpackage

// ----- rtl/core/lru_cell.sv -----
`timescale 1ns / 1ps
// One position of the recency chain: holds a page and its valid bit.
// Depends on lru_pkg for the control struct.
module lru_cell #(
  parameter int CELL_IDX  = 0,
  parameter int IDX_W     = 3,
  parameter int PAGE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lru_pkg::lru_ctl_t    ctl,
  input  logic [IDX_W-1:0]     stop,
  input  logic [PAGE_BITS-1:0] key,
  input  logic [PAGE_BITS-1:0] prev_page,
  input  logic                 prev_valid,
  output logic [PAGE_BITS-1:0] page_o,
  output logic                 valid_o,
  output logic                 hit_o
);
  import lru_pkg::*;

  logic [PAGE_BITS-1:0] page_r;
  logic                 valid_r;
  logic                 hit_r;
  logic                 hit_nxt;
  logic                 load;

  assign hit_nxt = valid_r && (page_r == key);
  // take the neighbor's word when this position's index is at or below the stop index
  assign load    = ctl.upd_en && (IDX_W'(CELL_IDX) <= stop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      hit_r   <= 1'b0;
    end else begin
      if (ctl.cmp_en) begin
        hit_r <= hit_nxt;
      end
      if (load) begin
        valid_r <= prev_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      page_r <= prev_page;
    end
  end

  assign page_o  = page_r;
  assign valid_o = valid_r;
  assign hit_o   = hit_r;

endmodule

// ----- rtl/core/lru_page_replacement.sv -----
`timescale 1ns / 1ps
// Top level of the LRU page replacement unit: sequencer, counters, result register.
// Depends on lru_pkg and a chain of lru_cell instances.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-------------------------
//  in      | in_page_number                          | in_valid / in_stall
//  out     | out_page_fault, out_evicted_valid,      | out_valid / out_stall
//          | out_evicted_page, out_fault_count       |
//  cfg     | cfg_frames_in_use                       | cfg_valid / cfg_ready
//
// Each reference passes a compare state, which matches the key against every cell of
// the chain, and an update state, which shifts the chain and loads the result register.
// A new word is taken in the update state, so the next reference enters while the last
// finishes. Reset (synchronous, rst_n low) empties the chain, zeroes the fault count
// and sets the frame limit to eight. A stalled result holds the update state and input.
module lru_page_replacement #(
  parameter int FRAME_COUNT = lru_pkg::FRAME_COUNT_DEF,
  parameter int PAGE_BITS   = lru_pkg::PAGE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [lru_pkg::PAGE_NUM_W-1:0] in_page_number,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_page_fault,
  output logic                           out_evicted_valid,
  output logic [lru_pkg::PAGE_NUM_W-1:0] out_evicted_page,
  output logic [lru_pkg::FAULT_W-1:0]    out_fault_count,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lru_pkg::CFG_W-1:0]      cfg_frames_in_use
);
  import lru_pkg::*;

  localparam int IDX_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int OCC_W = $clog2(FRAME_COUNT + 1);
  localparam int CW    = (OCC_W > CFG_W) ? OCC_W : CFG_W;

  lru_state_t state_r, state_nxt;
  lru_ctl_t   ctl;

  logic [CFG_W-1:0]     frames_r;
  logic [PAGE_BITS-1:0] key_r;
  logic [OCC_W-1:0]     occ_r;
  logic [FAULT_W-1:0]   faults_r, faults_nxt;

  logic                  out_valid_r;
  logic                  out_fault_r;
  logic                  out_ev_valid_r;
  logic [PAGE_NUM_W-1:0] out_ev_page_r;
  logic [FAULT_W-1:0]    out_count_r;

  logic [PAGE_BITS-1:0] cell_page [FRAME_COUNT];
  logic [FRAME_COUNT-1:0] cell_valid;
  logic [FRAME_COUNT-1:0] cell_hit;

  logic [31:0]          in_ext;
  logic [PAGE_BITS-1:0] key_nxt;
  logic                 in_fire;
  logic                 out_free;
  logic                 hit_any;
  logic [IDX_W-1:0]     hit_idx;
  logic [IDX_W-1:0]     last_idx;
  logic [IDX_W-1:0]     stop;
  logic [CW-1:0]        lim;
  logic [CW-1:0]        cfg_ext;
  logic                 room;
  logic                 evict;
  logic [PAGE_BITS-1:0] ev_page;
  logic [31:0]          ev_ext;

  // compare on the low PAGE_BITS bits of the referenced page
  assign in_ext  = 32'(in_page_number);
  assign key_nxt = in_ext[PAGE_BITS-1:0];

  assign out_free  = !out_valid_r || !out_stall;
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // sequencer: idle takes a word, compare cycle, then update cycle which may take the next
  always_comb begin
    state_nxt  = state_r;
    in_stall   = 1'b1;
    ctl.cmp_en = 1'b0;
    ctl.upd_en = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        ctl.cmp_en = 1'b1;
        state_nxt  = ST_UPD;
      end
      ST_UPD: begin
        if (out_free) begin
          ctl.upd_en = 1'b1;
          in_stall   = 1'b0;
          state_nxt  = in_valid ? ST_CMP : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // clamp the limit into 1..FRAME_COUNT
  assign cfg_ext = CW'(frames_r);
  always_comb begin
    if (frames_r == '0) begin
      lim = CW'(1);
    end else if (cfg_ext > CW'(FRAME_COUNT)) begin
      lim = CW'(FRAME_COUNT);
    end else begin
      lim = cfg_ext;
    end
  end

  assign room = CW'(occ_r) < lim;

  // at most one cell hits, so an OR encoder gives its position
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < FRAME_COUNT; i++) begin
      if (cell_hit[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  assign hit_any  = |cell_hit;
  assign last_idx = IDX_W'(occ_r - OCC_W'(1));
  assign evict    = !hit_any && !room;

  // hit: shift down to the hit cell; miss with room: grow by one; full: drop the tail
  always_comb begin
    if (hit_any) begin
      stop = hit_idx;
    end else if (room) begin
      stop = IDX_W'(occ_r);
    end else begin
      stop = last_idx;
    end
  end

  // tail cell holds the least recently used page
  always_comb begin
    ev_page = '0;
    for (int i = 0; i < FRAME_COUNT; i++) begin
      if (IDX_W'(i) == last_idx) begin
        ev_page = cell_page[i];
      end
    end
  end
  assign ev_ext = 32'(ev_page);

  assign faults_nxt = (faults_r == FAULT_MAX) ? faults_r : faults_r + FAULT_W'(1);

  for (genvar g = 0; g < FRAME_COUNT; g++) begin : g_cell
    logic [PAGE_BITS-1:0] prev_page;
    logic                 prev_valid;
    if (g == 0) begin : g_head
      assign prev_page  = key_r;
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_page  = cell_page[g-1];
      assign prev_valid = cell_valid[g-1];
    end
    lru_cell #(
      .CELL_IDX  (g),
      .IDX_W     (IDX_W),
      .PAGE_BITS (PAGE_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .stop       (stop),
      .key        (key_r),
      .prev_page  (prev_page),
      .prev_valid (prev_valid),
      .page_o     (cell_page[g]),
      .valid_o    (cell_valid[g]),
      .hit_o      (cell_hit[g])
    );
  end

  // control state: limit, occupancy, fault total, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_r    <= FRAMES_RESET;
      occ_r       <= '0;
      faults_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        frames_r <= cfg_frames_in_use;
      end
      if (ctl.upd_en) begin
        out_valid_r <= 1'b1;
        if (!hit_any) begin
          faults_r <= faults_nxt;
          if (room) begin
            occ_r <= occ_r + OCC_W'(1);
          end
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload: hold the key for the compare, load the result word on update
  always_ff @(posedge clk) begin
    if (in_fire) begin
      key_r <= key_nxt;
    end
    if (ctl.upd_en) begin
      out_fault_r    <= !hit_any;
      out_ev_valid_r <= evict;
      out_ev_page_r  <= evict ? ev_ext[PAGE_NUM_W-1:0] : '0;
      out_count_r    <= hit_any ? faults_r : faults_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_page_fault    = out_fault_r;
  assign out_evicted_valid = out_ev_valid_r;
  assign out_evicted_page  = out_ev_page_r;
  assign out_fault_count   = out_count_r;

`ifndef SYNTHESIS
  a_hit_unique: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |-> $onehot0(cell_hit))
    else $error("more than one cell matched the key");

  a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) == int'(occ_r))
    else $error("occupancy count disagrees with valid cells");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(occ_r) <= FRAME_COUNT)
    else $error("occupancy beyond the frame count");

  a_result_after_update: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_UPD))
    else $error("result word appeared outside an update cycle");

  a_evict_needs_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.upd_en && hit_any) |=> (!out_ev_valid_r && !out_fault_r))
    else $error("hit produced a fault or eviction");
`endif

endmodule

// ----- tb/lru_outcome_pkg.sv -----
`timescale 1ns / 1ps
// Result word type and recency-ordered page predictor with checker for the LRU unit.
// Depends on lru_pkg for field widths, frame count and reset constants.
package lru_outcome_pkg;
  import lru_pkg::*;

  typedef struct packed {
    logic                  page_fault;
    logic                  evicted_valid;
    logic [PAGE_NUM_W-1:0] evicted_page;
    logic [FAULT_W-1:0]    fault_count;
  } page_outcome_t;

  class lru_scoreboard;
    logic [PAGE_NUM_W-1:0] frame_page [FRAME_COUNT_DEF];
    bit                    frame_live [FRAME_COUNT_DEF];
    int unsigned           frame_age  [FRAME_COUNT_DEF];
    int unsigned           occupancy;
    logic [FAULT_W-1:0]    faults;
    logic [CFG_W-1:0]      limit_reg;
    page_outcome_t         outcome_q [$];
    int unsigned           errors;

    function new();
      foreach (frame_live[k]) begin
        frame_live[k] = 1'b0;
        frame_age[k]  = 0;
        frame_page[k] = '0;
      end
      occupancy = 0;
      faults    = '0;
      limit_reg = FRAMES_RESET;
      errors    = 0;
    endfunction

    function void set_limit(logic [CFG_W-1:0] v);
      limit_reg = v;
    endfunction

    // age live frames ranked below bound, then make slot the most recent
    function void promote(int slot, int unsigned bound);
      for (int k = 0; k < FRAME_COUNT_DEF; k++) begin
        if (k != slot && frame_live[k] && frame_age[k] < bound)
          frame_age[k]++;
      end
      frame_age[slot] = 0;
    endfunction

    function void note_reference(logic [PAGE_NUM_W-1:0] page);
      page_outcome_t exp;
      int            hit;
      int            slot;
      int            victim;
      int unsigned   cap;
      exp    = '0;
      hit    = -1;
      slot   = -1;
      victim = -1;
      cap = (limit_reg == 0) ? 1 :
            (limit_reg > FRAME_COUNT_DEF) ? FRAME_COUNT_DEF : limit_reg;
      for (int k = 0; k < FRAME_COUNT_DEF; k++) begin
        if (hit < 0 && frame_live[k] && frame_page[k] == page) hit = k;
      end
      if (hit >= 0) begin
        promote(hit, frame_age[hit]);
      end else begin
        exp.page_fault = 1'b1;
        if (faults != FAULT_MAX) faults++;
        if (occupancy < cap) begin
          for (int k = 0; k < FRAME_COUNT_DEF; k++) begin
            if (slot < 0 && !frame_live[k]) slot = k;
          end
        end
        if (slot >= 0) begin
          frame_live[slot] = 1'b1;
          frame_page[slot] = page;
          occupancy++;
          promote(slot, 256);
        end else begin
          // occupancy is at least the limit, so some frame is live here
          for (int k = 0; k < FRAME_COUNT_DEF; k++) begin
            if (frame_live[k] && (victim < 0 || frame_age[k] > frame_age[victim]))
              victim = k;
          end
          exp.evicted_valid = 1'b1;
          exp.evicted_page  = frame_page[victim];
          promote(victim, frame_age[victim]);
          frame_page[victim] = page;
        end
      end
      exp.fault_count = faults;
      outcome_q = {outcome_q, exp};
    endfunction

    function void check_outcome(page_outcome_t got);
      page_outcome_t exp;
      if (outcome_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: fault=%0d ev=%0d ev_page=%h count=%0d",
                   got.page_fault, got.evicted_valid, got.evicted_page, got.fault_count);
        return;
      end
      exp = outcome_q.pop_front();
      if (got.page_fault !== exp.page_fault || got.evicted_valid !== exp.evicted_valid ||
          got.evicted_page !== exp.evicted_page || got.fault_count !== exp.fault_count) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: expected fault=%0d ev=%0d ev_page=%h count=%0d,",
                    " got fault=%0d ev=%0d ev_page=%h count=%0d"},
                   exp.page_fault, exp.evicted_valid, exp.evicted_page, exp.fault_count,
                   got.page_fault, got.evicted_valid, got.evicted_page, got.fault_count);
      end
    endfunction
  endclass

endpackage

// ----- tb/tb_lru_page_replacement.sv -----
`timescale 1ns / 1ps
// Self-checking bench for lru_page_replacement: drives page references, predicts each result.
// Depends on lru_pkg, lru_outcome_pkg and the RTL of the unit.
module tb_lru_page_replacement;
  import lru_pkg::*;
  import lru_outcome_pkg::*;

  localparam int QUIET_LIMIT     = 2000;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int HOLD_CYCLES     = 80;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [PAGE_NUM_W-1:0] in_page_number;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_page_fault;
  logic                  out_evicted_valid;
  logic [PAGE_NUM_W-1:0] out_evicted_page;
  logic [FAULT_W-1:0]    out_fault_count;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_frames_in_use;

  lru_scoreboard sb;
  int unsigned   page_count   = 0;
  int unsigned   result_count = 0;

  lru_page_replacement dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_page_number    (in_page_number),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_page_fault    (out_page_fault),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_count   (out_fault_count),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_frames_in_use (cfg_frames_in_use)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Wait until every predicted result has been taken off the output.
  task automatic wait_drained();
    while (sb.outcome_q.size() != 0) @(posedge clk);
  endtask

  // Offer one reference word after a random gap; note it in the predictor once taken.
  // Leave valid high afterwards so back-to-back words need no extra edge.
  task automatic send_page(input logic [PAGE_NUM_W-1:0] page);
    int unsigned gap;
    // every 64 words, run 16 of them with no gap at all
    gap = (page_count % 64 < 16) ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_page_number <= page;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_reference(page);
    page_count++;
  endtask

  // Write the frame limit only once the unit is idle: drop input, drain, then handshake.
  task automatic set_frame_limit(input logic [CFG_W-1:0] v);
    in_valid <= 1'b0;
    wait_drained();
    cfg_valid         <= 1'b1;
    cfg_frames_in_use <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    sb.set_limit(v);
  endtask

  // Random references under one limit: mostly a small working set of the clamped limit plus
  // up to four pages (so hits and LRU evictions mix), the rest arbitrary page numbers.
  task automatic run_random_phase(input logic [CFG_W-1:0] limit, input int n_items);
    logic [PAGE_NUM_W-1:0] pool [$];
    logic [PAGE_NUM_W-1:0] page;
    int unsigned           usable;
    usable = (limit == 0) ? 1 : (limit > FRAME_COUNT_DEF) ? FRAME_COUNT_DEF : limit;
    set_frame_limit(limit);
    repeat (usable + $urandom_range(0, 4))
      pool = {pool, PAGE_NUM_W'($urandom_range(0, 16'hFFFF))};
    repeat (n_items) begin
      if ($urandom_range(0, 99) < 85) page = pool[$urandom_range(0, pool.size() - 1)];
      else page = PAGE_NUM_W'($urandom_range(0, 16'hFFFF));
      send_page(page);
    end
  endtask

  // Result side: take results, check them, stall at random between them.
  // Twice in the run, hold stall for a long stretch so the unit backs up into its input.
  initial begin : result_sink
    int unsigned   gap;
    int unsigned   hold;
    page_outcome_t got;
    gap  = 0;
    hold = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.page_fault    = out_page_fault;
        got.evicted_valid = out_evicted_valid;
        got.evicted_page  = out_evicted_page;
        got.fault_count   = out_fault_count;
        sb.check_outcome(got);
        result_count++;
        gap = (result_count % 64 < 16) ? 0 : $urandom_range(0, 10);
        if (result_count == 500 || result_count == 1300) hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if (gap > 0) begin
        gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Abort when no word moves on any channel for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [CFG_W-1:0] phase_limits [12];
    phase_limits = '{4'd3, 4'd5, 4'd8, 4'd0, 4'd12, 4'd1, 4'd6, 4'd15, 4'd2, 4'd7, 4'd4, 4'd8};
    sb = new();
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_page_number    <= '0;
    cfg_valid         <= 1'b0;
    cfg_frames_in_use <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Limit of zero acts as one frame: insert, hit, then each miss replaces the lone page.
    set_frame_limit(4'd0);
    send_page(16'h0000);
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h0000);

    // Two frames: insert into the free frame, refresh, then evict the older page.
    set_frame_limit(4'd2);
    send_page(16'h1234);
    send_page(16'h0000);
    send_page(16'hABCD);

    // Limit lowered below occupancy: misses replace the LRU page, occupancy holds at two.
    set_frame_limit(4'd1);
    send_page(16'h5555);
    send_page(16'hABCD);
    send_page(16'hAAAA);

    // Limit above the built frame count acts as the full count: inserts resume.
    set_frame_limit(4'd15);
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'hAAAA);
    send_page(16'h8001);

    // Random phases, limits grow and shrink so occupancy fills up over several settings.
    foreach (phase_limits[i]) run_random_phase(phase_limits[i], ITEMS_PER_PHASE);

    in_valid <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.outcome_q.size() != 0)
      $display("%0d expected results never arrived", sb.outcome_q.size());
    if (sb.errors == 0 && sb.outcome_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/lru_pkg.sv
rtl/core/lru_cell.sv
rtl/core/lru_page_replacement.sv
tb/lru_outcome_pkg.sv
tb/tb_lru_page_replacement.sv
